// ----- design/kst_pkg.sv -----
// ============================================================================
// kst_pkg: shared types and constants of the keyed slot table
// Opcodes, status codes, parameter defaults, controller states and a
// command word type.
// ============================================================================
package kst_pkg;

    localparam int DEF_ENTRIES   = 128;
    localparam int DEF_LISTENERS = 16;
    localparam int MAX_LISTENERS = 64;
    localparam int KEY_W         = 32;
    localparam int DATA_W        = 32;
    localparam int SLOT_W        = 6;
    localparam int FIRE_W        = 16;
    localparam int STAT_W        = 3;
    localparam int OP_W          = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP   = 3'd0,
        OP_ADD      = 3'd1,
        OP_MUTATE   = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_REG      = 3'd4,
        OP_UNREG    = 3'd5,
        OP_NOTIFY   = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_FULL        = 3'd3,
        ST_NO_LISTENER = 3'd4,
        ST_BAD_SLOT    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Command word with flags, opcode, key, data and slot.
    typedef struct packed {
        logic                      probe;   // compare key of the cell at the head
        logic                      upd;     // apply update to the head cell
        logic                      alloc;   // allocate the head cell on add
        op_t                       op;
        logic [KEY_W-1:0]          key;
        logic [DATA_W-1:0]         data;
        logic [SLOT_W-1:0]         slot;
    } cmd_t;

endpackage

// ----- design/kst_cell.sv -----
// ============================================================================
// kst_cell: one table entry in the rotating chain
// Holds one entry and passes it to its neighbor while the chain rotates.
// The cell at the head of the chain is the one that the controller examines.
// ============================================================================
module kst_cell #(
    parameter int LISTENERS = kst_pkg::DEF_LISTENERS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic                       prev_valid,
    input  logic [kst_pkg::KEY_W-1:0]  prev_key,
    input  logic [kst_pkg::DATA_W-1:0] prev_value,
    input  logic [LISTENERS-1:0]       prev_mask,
    output logic                       valid,
    output logic [kst_pkg::KEY_W-1:0]  key,
    output logic [kst_pkg::DATA_W-1:0] value,
    output logic [LISTENERS-1:0]       mask
);

    logic                       valid_reg;
    logic [kst_pkg::KEY_W-1:0]  key_reg;
    logic [kst_pkg::DATA_W-1:0] value_reg;
    logic [LISTENERS-1:0]       mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
            mask_reg  <= prev_mask;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign mask  = mask_reg;

endmodule

// ----- design/keyed_slot_table_with_listeners_unit.sv -----
// ============================================================================
// keyed_slot_table_with_listeners_unit: keyed table with listener masks
// Top level: controller plus a rotating chain of entry cells.
// ============================================================================
// The entries sit in a ring of cells that rotates one place per cycle while
// the block scans, so every entry passes the head cell once per rotation.
// The first rotation decides the match and the lowest free slot. The update
// is applied during a second rotation, as the chosen entry passes the head,
// and the ring ends in its original order. The word is accepted in the idle
// state and the result register is loaded from the done state. A stalled
// result holds the block in its done state. One word is worked on at a time.
module keyed_slot_table_with_listeners_unit #(
    parameter int ENTRIES   = kst_pkg::DEF_ENTRIES,
    parameter int LISTENERS = kst_pkg::DEF_LISTENERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kst_pkg::OP_W-1:0]      opcode,
    input  logic [kst_pkg::KEY_W-1:0]     key,
    input  logic [kst_pkg::DATA_W-1:0]    data_in,
    input  logic [kst_pkg::SLOT_W-1:0]    slot_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kst_pkg::STAT_W-1:0]    status,
    output logic [kst_pkg::DATA_W-1:0]    data_out,
    output logic [kst_pkg::SLOT_W-1:0]    slot_out,
    output logic [kst_pkg::FIRE_W-1:0]    fire_mask
);

    localparam int IDX_W = $clog2(ENTRIES + 1);
    localparam int LS_W  = (LISTENERS > 1) ? $clog2(LISTENERS) : 1;
    localparam logic [kst_pkg::SLOT_W:0] LIS_LIM = (kst_pkg::SLOT_W + 1)'(LISTENERS);

    // Ring of cells.
    logic                       c_valid [ENTRIES];
    logic [kst_pkg::KEY_W-1:0]  c_key   [ENTRIES];
    logic [kst_pkg::DATA_W-1:0] c_value [ENTRIES];
    logic [LISTENERS-1:0]       c_mask  [ENTRIES];

    // Head cell after any update; it feeds the tail.
    logic                       h_valid;
    logic [kst_pkg::KEY_W-1:0]  h_key;
    logic [kst_pkg::DATA_W-1:0] h_value;
    logic [LISTENERS-1:0]       h_mask;

    logic shift;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == ENTRIES - 1)
            begin : g_tail
                kst_cell #(.LISTENERS(LISTENERS)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .prev_valid(h_valid), .prev_key(h_key),
                    .prev_value(h_value), .prev_mask(h_mask),
                    .valid(c_valid[g]), .key(c_key[g]),
                    .value(c_value[g]), .mask(c_mask[g])
                );
            end
            else
            begin : g_mid
                kst_cell #(.LISTENERS(LISTENERS)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .prev_valid(c_valid[g+1]), .prev_key(c_key[g+1]),
                    .prev_value(c_value[g+1]), .prev_mask(c_mask[g+1]),
                    .valid(c_valid[g]), .key(c_key[g]),
                    .value(c_value[g]), .mask(c_mask[g])
                );
            end
        end
    endgenerate

    kst_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    // Captured command.
    kst_pkg::op_t                op_reg;
    logic [kst_pkg::KEY_W-1:0]   key_reg;
    logic [kst_pkg::DATA_W-1:0]  data_reg;
    logic [kst_pkg::SLOT_W-1:0]  slot_reg;

    // Scan results: position (count at which it passed the head).
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_pos_reg, hit_pos_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_pos_reg, free_pos_next;

    // Result register.
    logic                          out_valid_reg;
    logic [kst_pkg::STAT_W-1:0]    status_reg;
    logic [kst_pkg::DATA_W-1:0]    data_out_reg;
    logic [kst_pkg::SLOT_W-1:0]    slot_out_reg;
    logic [kst_pkg::FIRE_W-1:0]    fire_reg;

    logic accept, emit;
    logic head_match, head_free;
    assign accept     = in_valid && in_ready;
    assign head_match = c_valid[0] && (c_key[0] == key_reg);
    assign head_free  = !c_valid[0];

    // The first rotation (counts 0 to ENTRIES-1) searches. The second rotation
    // (counts ENTRIES to 2*ENTRIES-1) applies the update when the stored
    // position comes back to the head.
    localparam int CNT_W = $clog2(2 * ENTRIES + 1);
    logic [CNT_W-1:0] pc_reg, pc_next;
    logic             pass2;
    logic [IDX_W-1:0] pos2;
    assign pass2 = pc_reg >= CNT_W'(ENTRIES);
    assign pos2  = IDX_W'(pc_reg - CNT_W'(ENTRIES));

    logic do_upd, do_alloc;
    logic [LISTENERS-1:0] first_clear;
    logic                 any_clear;
    logic [kst_pkg::SLOT_W-1:0] first_idx;

    always_comb
    begin
        first_clear = '0;
        any_clear   = 1'b0;
        first_idx   = '0;
        for (int j = LISTENERS - 1; j >= 0; j--)
        begin
            if (!c_mask[0][j])
            begin
                first_clear = '0;
                first_clear[j] = 1'b1;
                any_clear   = 1'b1;
                first_idx   = kst_pkg::SLOT_W'(j);
            end
        end
    end

    always_comb
    begin
        do_upd   = (state_reg == kst_pkg::S_SCAN) && pass2 && hit_reg
                   && (hit_pos_reg == pos2);
        do_alloc = (state_reg == kst_pkg::S_SCAN) && pass2 && !hit_reg && free_reg
                   && (free_pos_reg == pos2) && (op_reg == kst_pkg::OP_ADD);
        h_valid = c_valid[0];
        h_key   = c_key[0];
        h_value = c_value[0];
        h_mask  = c_mask[0];
        if (do_alloc)
        begin
            h_valid = 1'b1;
            h_key   = key_reg;
            h_value = data_reg;
            h_mask  = '0;
        end
        else if (do_upd)
        begin
            unique case (op_reg)
                kst_pkg::OP_MUTATE: h_value = data_reg;
                kst_pkg::OP_REMOVE: h_valid = 1'b0;
                kst_pkg::OP_REG:    h_mask  = c_mask[0] | first_clear;
                kst_pkg::OP_UNREG:
                begin
                    if ({1'b0, slot_reg} < LIS_LIM)
                    begin
                        h_mask[slot_reg[LS_W-1:0]] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign shift = (state_reg == kst_pkg::S_SCAN);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kst_pkg::S_IDLE: if (accept) state_next = kst_pkg::S_SCAN;
            kst_pkg::S_SCAN:
                if (pc_reg == CNT_W'(2 * ENTRIES - 1)) state_next = kst_pkg::S_DONE;
            kst_pkg::S_DONE: if (!out_valid_reg || out_ready) state_next = kst_pkg::S_IDLE;
            default: state_next = kst_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath of the controller.
    always_comb
    begin
        pc_next       = pc_reg;
        hit_next      = hit_reg;
        hit_pos_next  = hit_pos_reg;
        free_next     = free_reg;
        free_pos_next = free_pos_reg;
        cnt_next      = cnt_reg;
        emit          = 1'b0;
        unique case (state_reg)
            kst_pkg::S_IDLE:
            begin
                pc_next   = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                cnt_next  = '0;
            end
            kst_pkg::S_SCAN:
            begin
                pc_next = pc_reg + 1'b1;
                if (!pass2)
                begin
                    if (head_match && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_pos_next = IDX_W'(pc_reg);
                    end
                    if (head_free && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_pos_next = IDX_W'(pc_reg);
                    end
                end
                if (do_upd || do_alloc) cnt_next = cnt_reg + 1'b1;
            end
            kst_pkg::S_DONE: emit = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // Result fields captured while the chosen entry passes the head.
    logic [kst_pkg::STAT_W-1:0] r_status_next;
    logic [kst_pkg::DATA_W-1:0] r_data_next;
    logic [kst_pkg::SLOT_W-1:0] r_slot_next;
    logic [kst_pkg::FIRE_W-1:0] r_fire_next;
    logic [kst_pkg::STAT_W-1:0] r_status_reg;
    logic [kst_pkg::DATA_W-1:0] r_data_reg;
    logic [kst_pkg::SLOT_W-1:0] r_slot_reg;
    logic [kst_pkg::FIRE_W-1:0] r_fire_reg;
    logic [kst_pkg::FIRE_W-1:0] mask16;

    always_comb
    begin
        mask16 = '0;
        for (int j = 0; j < LISTENERS && j < kst_pkg::FIRE_W; j++)
        begin
            mask16[j] = c_mask[0][j];
        end
    end

    always_comb
    begin
        r_status_next = r_status_reg;
        r_data_next   = r_data_reg;
        r_slot_next   = r_slot_reg;
        r_fire_next   = r_fire_reg;
        if (state_reg == kst_pkg::S_IDLE)
        begin
            r_status_next = kst_pkg::ST_OK;
            r_data_next   = '0;
            r_slot_next   = '0;
            r_fire_next   = '0;
        end
        else if ((state_reg == kst_pkg::S_SCAN) && (pc_reg == CNT_W'(ENTRIES)))
        begin
            // End of the search pass: settle the miss cases.
            if (op_reg == kst_pkg::OP_ADD)
            begin
                if (hit_reg)       r_status_next = kst_pkg::ST_DUPLICATE;
                else if (!free_reg) r_status_next = kst_pkg::ST_FULL;
            end
            else if (op_reg != kst_pkg::OP_NONE && !hit_reg)
            begin
                r_status_next = kst_pkg::ST_NOT_FOUND;
            end
        end
        if (do_upd)
        begin
            unique case (op_reg) inside
                kst_pkg::OP_LOOKUP: r_data_next = c_value[0];
                kst_pkg::OP_MUTATE, kst_pkg::OP_NOTIFY: r_fire_next = mask16;
                kst_pkg::OP_REG:
                begin
                    if (any_clear) r_slot_next = first_idx;
                    else           r_status_next = kst_pkg::ST_NO_LISTENER;
                end
                kst_pkg::OP_UNREG:
                    if ({1'b0, slot_reg} >= LIS_LIM)
                        r_status_next = kst_pkg::ST_BAD_SLOT;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kst_pkg::S_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_pos_reg  <= hit_pos_next;
        free_pos_reg <= free_pos_next;
        r_status_reg <= r_status_next;
        r_data_reg   <= r_data_next;
        r_slot_reg   <= r_slot_next;
        r_fire_reg   <= r_fire_next;
        if (accept)
        begin
            op_reg   <= kst_pkg::op_t'(opcode);
            key_reg  <= key;
            data_reg <= data_in;
            slot_reg <= slot_in;
        end
        if (emit)
        begin
            status_reg   <= r_status_reg;
            data_out_reg <= r_data_reg;
            slot_out_reg <= r_slot_reg;
            fire_reg     <= r_fire_reg;
        end
    end

    assign in_ready  = (state_reg == kst_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign slot_out  = slot_out_reg;
    assign fire_mask = fire_reg;

    // At most one entry is changed per word.
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kst_pkg::S_DONE) |-> (cnt_reg <= IDX_W'(1)))
        else $error("more than one entry updated for one word");

    // No word is taken while a scan is in progress.
    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kst_pkg::S_SCAN) |-> !in_ready)
        else $error("input accepted during scan");

    // A result is only raised from the done state.
    a_emit_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == kst_pkg::S_DONE))
        else $error("result raised outside done state");

endmodule
